// ===== rtl/pidl_pkg.sv =====
`timescale 1ns / 1ps

package pidl_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 2;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;
    // compare width: holds count + 1 and any position without overflow
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GET    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   read_value;
        logic [LEN_W-1:0]    list_length;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

// ===== rtl/pidl_ram.sv =====
`timescale 1ns / 1ps

module pidl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pidl_ctrl.sv =====
`timescale 1ns / 1ps

module pidl_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pidl_pkg::KIND_W-1:0]   kind,
    input  logic [pidl_pkg::POS_W-1:0]    position,
    input  logic [pidl_pkg::DATA_W-1:0]   value,
    output pidl_pkg::ram_req_t            ram_req,
    input  logic [pidl_pkg::DATA_W-1:0]   ram_rdata,
    input  logic                          res_ready,
    output logic                          res_done,
    output pidl_pkg::result_t             res
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS_STEP = 3'd1;
    localparam logic [2:0] S_INS_WR   = 3'd2;
    localparam logic [2:0] S_DEL_CAP  = 3'd3;
    localparam logic [2:0] S_DEL_STEP = 3'd4;
    localparam logic [2:0] S_DEL_WR   = 3'd5;
    localparam logic [2:0] S_GET_CAP  = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0]                      state_reg, state_next;
    logic [pidl_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [pidl_pkg::CNT_W-1:0]      ptr_reg, ptr_next;
    logic [pidl_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [pidl_pkg::DATA_W-1:0]     value_reg, value_next;
    logic [pidl_pkg::DATA_W-1:0]     rd_reg, rd_next;
    logic [pidl_pkg::STATUS_W-1:0]   status_reg, status_next;

    logic                            accept;
    logic                            step_down;
    logic [pidl_pkg::CNT_W-1:0]      ptr_step;
    logic [pidl_pkg::CMP_W-1:0]      pos_w;
    logic [pidl_pkg::CMP_W-1:0]      cnt_w;
    logic                            ins_bad;
    logic                            acc_bad;
    logic                            full;
    logic [pidl_pkg::POS_W-1:0]      pos_m1;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    // one shared step unit: moves the pointer down for insert, up for delete
    assign step_down = (state_reg == S_INS_STEP) || (state_reg == S_INS_WR);
    assign ptr_step  = ptr_reg + (step_down ? {pidl_pkg::CNT_W{1'b1}}
                                            : pidl_pkg::CNT_W'(1));

    assign pos_w   = pidl_pkg::CMP_W'(position);
    assign cnt_w   = pidl_pkg::CMP_W'(count_reg);
    assign ins_bad = (pos_w == '0) || (pos_w > cnt_w + pidl_pkg::CMP_W'(1));
    assign acc_bad = (pos_w == '0) || (pos_w > cnt_w);
    assign full    = (count_reg == pidl_pkg::CNT_W'(pidl_pkg::CAPACITY));
    assign pos_m1  = position - pidl_pkg::POS_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        pos_next      = pos_reg;
        value_next    = value_reg;
        rd_next       = rd_reg;
        status_next   = status_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = ptr_reg[pidl_pkg::ADDR_W-1:0];
        ram_req.wdata = ram_rdata;
        ram_req.raddr = ptr_step[pidl_pkg::ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                ram_req.raddr = pidl_pkg::ADDR_W'(pos_m1);
                if (accept)
                begin
                    pos_next    = position;
                    value_next  = value;
                    rd_next     = '0;
                    status_next = pidl_pkg::ST_OK;
                    case (kind)
                        pidl_pkg::KIND_INSERT:
                        begin
                            if (ins_bad)
                            begin
                                status_next = pidl_pkg::ST_RANGE;
                                state_next  = S_DONE;
                            end
                            else if (full)
                            begin
                                status_next = pidl_pkg::ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                state_next = S_INS_STEP;
                            end
                        end
                        pidl_pkg::KIND_DELETE:
                        begin
                            if (acc_bad)
                            begin
                                status_next = pidl_pkg::ST_RANGE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                ptr_next   = pidl_pkg::CNT_W'(pos_m1);
                                state_next = S_DEL_CAP;
                            end
                        end
                        pidl_pkg::KIND_GET:
                        begin
                            if (acc_bad)
                            begin
                                status_next = pidl_pkg::ST_RANGE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_GET_CAP;
                            end
                        end
                        default:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_INS_STEP:
            begin
                if (pidl_pkg::CMP_W'(ptr_reg) >= pidl_pkg::CMP_W'(pos_reg))
                begin
                    // fetch entry below the hole
                    state_next = S_INS_WR;
                end
                else
                begin
                    ram_req.we    = 1'b1;
                    ram_req.wdata = value_reg;
                    count_next    = count_reg + pidl_pkg::CNT_W'(1);
                    state_next    = S_DONE;
                end
            end
            S_INS_WR:
            begin
                ram_req.we = 1'b1;
                ptr_next   = ptr_step;
                state_next = S_INS_STEP;
            end
            S_DEL_CAP:
            begin
                rd_next    = ram_rdata;
                state_next = S_DEL_STEP;
            end
            S_DEL_STEP:
            begin
                if (pidl_pkg::CMP_W'(ptr_step) < cnt_w)
                begin
                    state_next = S_DEL_WR;
                end
                else
                begin
                    count_next = count_reg - pidl_pkg::CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_DEL_WR:
            begin
                ram_req.we = 1'b1;
                ptr_next   = ptr_step;
                state_next = S_DEL_STEP;
            end
            S_GET_CAP:
            begin
                rd_next    = ram_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        value_reg  <= value_next;
        rd_reg     <= rd_next;
        status_reg <= status_next;
    end

    assign res_done        = (state_reg == S_DONE) && res_ready;
    assign res.status      = status_reg;
    assign res.read_value  = rd_reg;
    assign res.list_length = pidl_pkg::LEN_W'(count_reg);

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pidl_pkg::CNT_W'(pidl_pkg::CAPACITY))
        else $error("list count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (state_reg == S_INS_STEP || state_reg == S_INS_WR
                        || state_reg == S_DEL_WR))
        else $error("memory write outside a shift or insert step");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (ptr_reg < pidl_pkg::CNT_W'(pidl_pkg::CAPACITY)))
        else $error("memory write beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEL_STEP && state_next == S_DONE)
        |=> (count_reg == $past(count_reg) - pidl_pkg::CNT_W'(1)))
        else $error("delete did not shrink the list by one");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !in_valid) |=> (state_reg == S_IDLE))
        else $error("sequencer left idle without a request");

endmodule

// ===== rtl/positional_insert_delete_list.sv =====
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values in a single-port-write
// RAM, driven by a small sequencer that moves one entry per step and write state.
// A request is taken only while the sequencer is idle; the finished result
// goes to an output register, so a new request may be taken while it waits.
// Insert and delete shift the entries behind the position one at a time
// through the RAM's one read and one write port; get reads one entry, and
// clear or a refused request goes straight to the result. A stalled output
// holds the sequencer in its done state until the output register is free.
module positional_insert_delete_list (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [pidl_pkg::KIND_W-1:0]       kind,
    input  logic [pidl_pkg::POS_W-1:0]        position,
    input  logic signed [pidl_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [pidl_pkg::STATUS_W-1:0]     status,
    output logic signed [pidl_pkg::DATA_W-1:0] read_value,
    output logic [pidl_pkg::LEN_W-1:0]        list_length
);

    pidl_pkg::ram_req_t           ram_req;
    logic [pidl_pkg::DATA_W-1:0]  ram_rdata;
    pidl_pkg::result_t            res;
    logic                         res_done;
    logic                         res_ready;

    logic                         out_valid_reg, out_valid_next;
    pidl_pkg::result_t            out_reg;

    pidl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .position  (position),
        .value     (value),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_ready (res_ready),
        .res_done  (res_done),
        .res       (res)
    );

    pidl_ram #(
        .WIDTH (pidl_pkg::DATA_W),
        .DEPTH (pidl_pkg::CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_done)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign read_value  = out_reg.read_value;
    assign list_length = out_reg.list_length;

endmodule
